@@ src/ndq_pkg.sv @@
// shared types, register codes and conversion functions for the element dequantizer
package ndq_pkg;

    localparam logic [3:0] FMT_FP32   = 4'd0;
    localparam logic [3:0] FMT_INT32  = 4'd1;
    localparam logic [3:0] FMT_UINT32 = 4'd2;
    localparam logic [3:0] FMT_FP16   = 4'd3;
    localparam logic [3:0] FMT_BF16   = 4'd4;
    localparam logic [3:0] FMT_INT16  = 4'd5;
    localparam logic [3:0] FMT_UINT16 = 4'd6;
    localparam logic [3:0] FMT_INT8   = 4'd8;
    localparam logic [3:0] FMT_CHAR   = 4'd9;

    localparam logic [1:0] QM_DFP    = 2'd1;
    localparam logic [1:0] QM_AFFINE = 2'd2;

    localparam logic [2:0] REG_FMT   = 3'd0;
    localparam logic [2:0] REG_QMODE = 3'd1;
    localparam logic [2:0] REG_FPOS  = 3'd2;
    localparam logic [2:0] REG_ZOFF  = 3'd3;
    localparam logic [2:0] REG_SCALE = 3'd4;

    localparam logic [31:0] SCALE_RESET = 32'h3F80_0000;
    localparam logic [31:0] CANON_NAN   = 32'h7FC0_0000;
    localparam logic [31:0] POS_INF     = 32'h7F80_0000;

    typedef struct packed {
        logic [3:0]         fmt;
        logic [1:0]         qmode;
        logic signed [7:0]  fpos;
        logic signed [31:0] zoff;
        logic [31:0]        scale;
    } t_cfg;

    // multiplier operand and bypass data carried down the pipeline
    typedef struct packed {
        logic              sm;
        logic              nan;
        logic              inf;
        logic              zero;
        logic [23:0]       mm;
        logic signed [8:0] em;
        logic              byp;
        logic [31:0]       bypv;
    } t_mop;

    typedef struct packed {
        logic [23:0]       man;
        logic signed [6:0] ex;
    } t_rnd;

    function automatic logic [5:0] msb36(input logic [35:0] m);
        logic [5:0] p;
        p = 6'd0;
        for (int i = 0; i < 36; i++) begin
            if (m[i]) p = 6'(i);
        end
        return p;
    endfunction

    // round a magnitude to 24 significant bits, value = man * 2^ex
    function automatic t_rnd rnd24(input logic [35:0] m);
        logic [5:0]  p;
        logic [35:0] nrm;
        logic        up;
        logic [24:0] sum;
        t_rnd        r;
        p   = msb36(m);
        nrm = m << (6'd35 - p);
        up  = nrm[11] & ((|nrm[10:0]) | nrm[12]);
        sum = {1'b0, nrm[35:12]} + 25'(up);
        r.ex = $signed({1'b0, p}) - 7'sd23;
        if (sum[24]) begin
            r.man = 24'h80_0000;
            r.ex  = r.ex + 7'sd1;
        end else begin
            r.man = sum[23:0];
        end
        if (m == 36'd0) begin
            r.man = 24'd0;
            r.ex  = 7'sd0;
        end
        return r;
    endfunction

    // integer rounded to the nearest single value, kept as an integer
    function automatic logic [35:0] round_int(input logic [35:0] m);
        t_rnd r;
        r = rnd24(m);
        if (r.ex <= 7'sd0) return m;
        return 36'(r.man) << r.ex[3:0];
    endfunction

    function automatic logic [31:0] half_to_single(input logic [15:0] h);
        logic [31:0] sgn;
        logic [4:0]  e;
        logic [9:0]  m;
        logic [3:0]  t;
        logic [9:0]  mn;
        logic [7:0]  ex;
        sgn = {h[15], 31'd0};
        e   = h[14:10];
        m   = h[9:0];
        t   = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (m[i]) t = 4'(i);
        end
        mn = m << (4'd10 - t);
        ex = 8'd103 + 8'(t);
        if (e == 5'd0) begin
            if (m == 10'd0) return sgn;
            return sgn | {1'b0, ex, mn, 13'd0};
        end
        if (e == 5'h1F) return sgn | POS_INF | {9'd0, m, 13'd0};
        return sgn | {1'b0, 8'(e) + 8'd112, m, 13'd0};
    endfunction

endpackage

@@ src/ndq_apb_regs.sv @@
// configuration register file with its apb write and read port
module ndq_apb_regs import ndq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [4:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    logic w_wr;
    logic [2:0] w_idx;

    assign o_pready = 1'b1;
    assign w_wr     = i_psel & i_penable & i_pwrite;
    assign w_idx    = i_paddr[4:2];
    assign o_cfg    = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fmt   <= FMT_FP32;
            r_cfg.qmode <= 2'd0;
            r_cfg.fpos  <= 8'sd0;
            r_cfg.zoff  <= 32'sd0;
            r_cfg.scale <= SCALE_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_FMT:   r_cfg.fmt   <= i_pwdata[3:0];
                REG_QMODE: r_cfg.qmode <= i_pwdata[1:0];
                REG_FPOS:  r_cfg.fpos  <= $signed(i_pwdata[7:0]);
                REG_ZOFF:  r_cfg.zoff  <= $signed(i_pwdata);
                REG_SCALE: r_cfg.scale <= i_pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_FMT:   o_prdata = {28'd0, r_cfg.fmt};
            REG_QMODE: o_prdata = {30'd0, r_cfg.qmode};
            REG_FPOS:  o_prdata = {24'd0, r_cfg.fpos};
            REG_ZOFF:  o_prdata = r_cfg.zoff;
            REG_SCALE: o_prdata = r_cfg.scale;
            default:   o_prdata = 32'd0;
        endcase
    end

endmodule

@@ src/npu_tensor_element_dequantizer.sv @@
// Tensor element dequantizer: one raw little-endian element in, one IEEE single out.
// The block takes one request per clock while its input is open, and each result
// passes the input register and every stage behind it before it reaches the output.
// The depth is set by the operand decode, integer rounding, subtract, difference
// rounding, 24x24 multiply and final rounding stages behind the input register.
// Every stage holds its own valid bit, so bubbles close up and input stays open
// while any stage is free; input closes only when all seven stages hold an item and
// the output is stalled. Registers sit on the APB port at byte addresses 0 (format),
// 4 (quant mode), 8 (fraction position), 12 (zero point) and 16 (scale); write them
// only while the block is idle.
module npu_tensor_element_dequantizer import ndq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // raw_element
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // real_bits
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [4:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    t_cfg w_cfg;

    ndq_apb_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready),
        .o_cfg     (w_cfg)
    );

    logic [6:0] r_vld;
    logic [6:0] w_en;

    always_comb begin
        w_en[6] = !r_vld[6] || i_m_axis_tready;
        for (int k = 5; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign o_s_axis_tready = w_en[0];
    assign o_m_axis_tvalid = r_vld[6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 7'd0;
        end else begin
            if (w_en[0]) r_vld[0] <= i_s_axis_tvalid;
            for (int k = 1; k < 7; k++) begin
                if (w_en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // stage 0: input register
    logic [31:0] r0_raw;
    always_ff @(posedge i_clk) begin
        if (w_en[0]) r0_raw <= i_s_axis_tdata;
    end

    // stage 1: operand selection and multiplier operand decode
    logic signed [32:0] w_s8, w_s16, w_s32, w_rds, w_v;
    logic [32:0]        w_rdu;
    logic               w_sfmt, w_zsel, w_flt;
    logic [31:0]        w_m, w_fac, w_bypv;
    logic signed [8:0]  w_pexp;
    logic [7:0]         w_me;
    logic [22:0]        w_mf;
    logic [4:0]         w_mt;
    t_mop               w_mop1;

    always_comb begin
        w_s8   = 33'(signed'(r0_raw[7:0]));
        w_s16  = 33'(signed'(r0_raw[15:0]));
        w_s32  = 33'(signed'(r0_raw));
        w_sfmt = (w_cfg.fmt == FMT_INT8) || (w_cfg.fmt == FMT_INT16) ||
                 (w_cfg.fmt == FMT_INT32) || (w_cfg.fmt == FMT_CHAR);
        case (w_cfg.fmt)
            FMT_INT16: w_rds = w_s16;
            FMT_INT32: w_rds = w_s32;
            default:   w_rds = w_s8;
        endcase
        case (w_cfg.fmt)
            FMT_UINT16: w_rdu = {17'd0, r0_raw[15:0]};
            FMT_UINT32: w_rdu = {1'b0, r0_raw};
            default:    w_rdu = {25'd0, r0_raw[7:0]};
        endcase
        w_pexp = 9'sd127 - 9'(w_cfg.fpos);
        if (w_cfg.fpos == -8'sd128) w_fac = POS_INF;
        else if (w_cfg.fpos == 8'sd127) w_fac = 32'h0040_0000;
        else w_fac = {1'b0, w_pexp[7:0], 23'd0};

        w_flt = (w_cfg.fmt == FMT_FP32) || (w_cfg.fmt == FMT_FP16) ||
                (w_cfg.fmt == FMT_BF16);
        case (w_cfg.fmt)
            FMT_FP16: w_bypv = half_to_single(r0_raw[15:0]);
            FMT_BF16: w_bypv = {r0_raw[15:0], 16'd0};
            default:  w_bypv = r0_raw;
        endcase

        w_zsel = 1'b0;
        w_mop1.byp  = 1'b0;
        w_mop1.bypv = w_bypv;
        if (w_cfg.qmode == QM_DFP) begin
            w_v = w_rds;
            w_m = w_fac;
        end else if (w_cfg.qmode == QM_AFFINE) begin
            w_v    = w_sfmt ? w_rds : $signed(w_rdu);
            w_m    = w_cfg.scale;
            w_zsel = 1'b1;
        end else begin
            w_v        = w_sfmt ? w_rds : $signed(w_rdu);
            w_m        = SCALE_RESET;
            w_mop1.byp = w_flt;
        end

        w_me = w_m[30:23];
        w_mf = w_m[22:0];
        w_mt = 5'd0;
        for (int i = 0; i < 23; i++) begin
            if (w_mf[i]) w_mt = 5'(i);
        end
        w_mop1.sm   = w_m[31];
        w_mop1.nan  = (w_me == 8'hFF) && (w_mf != 23'd0);
        w_mop1.inf  = (w_me == 8'hFF) && (w_mf == 23'd0);
        w_mop1.zero = (w_me == 8'd0) && (w_mf == 23'd0);
        if (w_me == 8'd0) begin
            w_mop1.mm = 24'(w_mf) << (5'd23 - w_mt);
            w_mop1.em = -9'sd172 + $signed({4'd0, w_mt});
        end else begin
            w_mop1.mm = {1'b1, w_mf};
            w_mop1.em = $signed({1'b0, w_me}) - 9'sd150;
        end
    end

    logic        r1_vs, r1_zs;
    logic [32:0] r1_vm;
    logic [31:0] r1_zm;
    t_mop        r1_mop;
    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r1_vs  <= w_v[32];
            r1_vm  <= w_v[32] ? 33'(-w_v) : 33'(w_v);
            r1_zs  <= w_zsel & w_cfg.zoff[31];
            r1_zm  <= (w_zsel & w_cfg.zoff[31]) ? 32'(-w_cfg.zoff) :
                      (w_zsel ? w_cfg.zoff : 32'd0);
            r1_mop <= w_mop1;
        end
    end

    // stage 2: both integers rounded to single precision
    logic        r2_as, r2_bs;
    logic [35:0] r2_am, r2_bm;
    t_mop        r2_mop;
    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r2_as  <= r1_vs;
            r2_am  <= round_int(36'(r1_vm));
            r2_bs  <= r1_zs;
            r2_bm  <= round_int(36'(r1_zm));
            r2_mop <= r1_mop;
        end
    end

    // stage 3: exact difference
    logic signed [37:0] w_a, w_b, w_d;
    always_comb begin
        w_a = r2_as ? -$signed({2'b0, r2_am}) : $signed({2'b0, r2_am});
        w_b = r2_bs ? -$signed({2'b0, r2_bm}) : $signed({2'b0, r2_bm});
        w_d = w_a - w_b;
    end

    logic        r3_ds;
    logic [35:0] r3_dm;
    t_mop        r3_mop;
    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r3_ds  <= w_d[37];
            r3_dm  <= w_d[37] ? 36'(-w_d) : 36'(w_d);
            r3_mop <= r2_mop;
        end
    end

    // stage 4: difference rounded to single precision
    t_rnd w_dr;
    assign w_dr = rnd24(r3_dm);

    logic [23:0]       r4_md;
    logic signed [6:0] r4_ed;
    logic              r4_ds;
    t_mop              r4_mop;
    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r4_md  <= w_dr.man;
            r4_ed  <= w_dr.ex;
            r4_ds  <= r3_ds;
            r4_mop <= r3_mop;
        end
    end

    // stage 5: significand product
    logic [47:0]       r5_p;
    logic signed [9:0] r5_et;
    logic              r5_s, r5_dz;
    t_mop              r5_mop;
    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r5_p   <= r4_md * r4_mop.mm;
            r5_et  <= 10'(r4_ed) + 10'(r4_mop.em);
            r5_s   <= r4_ds ^ r4_mop.sm;
            r5_dz  <= (r4_md == 24'd0);
            r5_mop <= r4_mop;
        end
    end

    // stage 6: normalize, round and pack
    logic signed [10:0] w_e;
    logic [47:0]        w_pn;
    logic [4:0]         w_sh;
    logic [9:0]         w_eeff;
    logic [71:0]        w_q;
    logic               w_up;
    logic [24:0]        w_rnd;
    logic [33:0]        w_body;
    logic [31:0]        w_res;

    always_comb begin
        w_e  = 11'(r5_et) + 11'sd173 + $signed({10'd0, r5_p[47]});
        w_pn = r5_p[47] ? r5_p : (r5_p << 1);
        if (w_e < 11'sd1) begin
            w_sh   = 5'(11'sd1 - w_e);
            w_eeff = 10'd0;
        end else begin
            w_sh   = 5'd0;
            w_eeff = w_e[9:0];
        end
        w_q   = {w_pn, 24'd0} >> w_sh;
        w_up  = w_q[47] & ((|w_q[46:0]) | w_q[48]);
        w_rnd = {1'b0, w_q[71:48]} + 25'(w_up);
        if (w_eeff == 10'd0) w_body = 34'(w_rnd);
        else w_body = {11'(w_eeff) - 11'd1, 23'd0} + 34'(w_rnd);

        if (r5_mop.byp) w_res = r5_mop.bypv;
        else if (r5_mop.nan || (r5_mop.inf && r5_dz)) w_res = CANON_NAN;
        else if (r5_mop.inf) w_res = {r5_s, POS_INF[30:0]};
        else if (r5_dz || r5_mop.zero) w_res = {r5_s, 31'd0};
        else if (w_body[33:23] >= 11'd255) w_res = {r5_s, POS_INF[30:0]};
        else w_res = {r5_s, w_body[30:0]};
    end

    logic [31:0] r6_data;
    logic        r6_byp;
    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r6_data <= w_res;
            r6_byp  <= r5_mop.byp;
        end
    end

    assign o_m_axis_tdata = r6_data;

    // input closes only when every stage holds an item
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r_vld == 7'h7F))
        else $error("input stalled with a free stage");

    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> r_vld[0])
        else $error("accepted request lost at input stage");

    a_canon_nan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[6] && !r6_byp && (r6_data[30:23] == 8'hFF) && (r6_data[22:0] != 23'd0))
        |-> (r6_data == CANON_NAN))
        else $error("computed nan not canonical");

endmodule

@@ tb/tb_top.sv @@
// testbench for the tensor element dequantizer: directed and random requests checked against a bit-exact predictor
`timescale 1ns / 100ps

module tb_top;
    import ndq_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 20;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata;   // raw_element
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [31:0] o_m_axis_tdata;   // real_bits
    logic        i_psel;
    logic        i_penable;
    logic        i_pwrite;
    logic [4:0]  i_paddr;
    logic [31:0] i_pwdata;
    logic [31:0] o_prdata;
    logic        o_pready;

    npu_tensor_element_dequantizer dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid), .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata(i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid), .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata(o_m_axis_tdata),
        .i_psel(i_psel), .i_penable(i_penable), .i_pwrite(i_pwrite),
        .i_paddr(i_paddr), .i_pwdata(i_pwdata), .o_prdata(o_prdata), .o_pready(o_pready)
    );

    logic [3:0]         cfg_fmt;
    logic [1:0]         cfg_qmode;
    logic signed [7:0]  cfg_fpos;
    logic signed [31:0] cfg_zoff;
    logic [31:0]        cfg_scale;

    logic [31:0] expected_real_q[$];
    int          mismatch_count;
    int          cycle_count;
    int          send_idle_pct;
    int          recv_stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ---------------- predictor ----------------

    // round sign * mag * 2^ex to single precision, nearest even
    function automatic logic [31:0] round_to_single(input logic sgn, input logic [63:0] mag,
                                                    input int ex);
        int          p;
        int          biased;
        int          sh;
        logic [63:0] man;
        logic [63:0] rem;
        logic [63:0] half;
        logic [31:0] r;
        if (mag == 64'd0) return {sgn, 31'd0};
        p = 0;
        for (int i = 0; i < 64; i++) begin
            if (mag[i]) p = i;
        end
        if (p + ex > 127) return {sgn, 8'hFF, 23'd0};
        biased = p + ex + 127;
        sh = (biased >= 1) ? p - 23 : -149 - ex;
        if (sh <= 0) begin
            man = mag << (-sh);
        end else if (sh >= 64) begin
            man = 64'd0;
        end else begin
            man  = mag >> sh;
            rem  = mag & ((64'd1 << sh) - 64'd1);
            half = 64'd1 << (sh - 1);
            if (rem > half || (rem == half && man[0])) man = man + 64'd1;
        end
        if (biased >= 1) r = 32'((biased - 1) << 23) + man[31:0];
        else r = man[31:0];
        return {sgn, r[30:0]};
    endfunction

    function automatic void split_single(input logic [31:0] b, output logic [63:0] mag,
                                         output int ex);
        if (b[30:23] == 8'd0) begin
            mag = {41'd0, b[22:0]};
            ex  = -149;
        end else begin
            mag = {40'd0, 1'b1, b[22:0]};
            ex  = int'(b[30:23]) - 150;
        end
    endfunction

    function automatic logic [31:0] int_to_single(input longint v);
        return round_to_single(v < 0, (v < 0) ? 64'(-v) : 64'(v), 0);
    endfunction

    // exact integer value of a single that holds an integer
    function automatic longint single_to_int(input logic [31:0] b);
        logic [63:0] mag;
        int          ex;
        longint      v;
        split_single(b, mag, ex);
        v = (ex >= 0) ? longint'(mag << ex) : longint'(mag >> (-ex));
        return b[31] ? -v : v;
    endfunction

    function automatic longint signed_element(input logic [31:0] raw, input logic [3:0] fmt);
        if (fmt == FMT_INT16) return longint'($signed(raw[15:0]));
        if (fmt == FMT_INT32) return longint'($signed(raw));
        return longint'($signed(raw[7:0]));
    endfunction

    function automatic longint integer_element(input logic [31:0] raw, input logic [3:0] fmt);
        longint v;
        if (fmt == FMT_INT8 || fmt == FMT_INT16 || fmt == FMT_INT32 || fmt == FMT_CHAR)
            return signed_element(raw, fmt);
        if (fmt == FMT_UINT16) v = raw[15:0];
        else if (fmt == FMT_UINT32) v = raw;
        else v = raw[7:0];
        return v;
    endfunction

    function automatic logic [31:0] widen_half(input logic [15:0] h);
        int       e;
        logic [10:0] m;
        e = h[14:10];
        m = {1'b0, h[9:0]};
        if (e == 0) begin
            if (m == 11'd0) return {h[15], 31'd0};
            e = 113;
            while (!m[10]) begin
                m = m << 1;
                e = e - 1;
            end
            return {h[15], 8'(e), m[9:0], 13'd0};
        end
        if (e == 31) return {h[15], 8'hFF, m[9:0], 13'd0};
        return {h[15], 8'(e + 112), m[9:0], 13'd0};
    endfunction

    function automatic logic [31:0] dequant_expect(input logic [31:0] raw);
        longint      v;
        longint      diff;
        logic [31:0] f;
        logic [31:0] d;
        logic [63:0] m1;
        logic [63:0] m2;
        int          e1;
        int          e2;
        if (cfg_qmode == QM_DFP) begin
            v = signed_element(raw, cfg_fmt);
            if (cfg_fpos == -8'sd128) begin
                if (v == 0) return CANON_NAN;
                return (v < 0) ? 32'hFF80_0000 : POS_INF;
            end
            f = int_to_single(v);
            split_single(f, m1, e1);
            return round_to_single(f[31], m1, e1 - int'(cfg_fpos));
        end
        if (cfg_qmode == QM_AFFINE) begin
            diff = single_to_int(int_to_single(integer_element(raw, cfg_fmt)))
                 - single_to_int(int_to_single(longint'(cfg_zoff)));
            d = int_to_single(diff);
            if (cfg_scale[30:23] == 8'hFF) begin
                if (cfg_scale[22:0] != 23'd0 || d[30:0] == 31'd0) return CANON_NAN;
                return {d[31] ^ cfg_scale[31], 8'hFF, 23'd0};
            end
            split_single(d, m1, e1);
            split_single(cfg_scale, m2, e2);
            return round_to_single(d[31] ^ cfg_scale[31], m1 * m2, e1 + e2);
        end
        if (cfg_fmt == FMT_FP32) return raw;
        if (cfg_fmt == FMT_FP16) return widen_half(raw[15:0]);
        if (cfg_fmt == FMT_BF16) return {raw[15:0], 16'd0};
        return int_to_single(integer_element(raw, cfg_fmt));
    endfunction

    // ---------------- monitors ----------------

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                expected_real_q.push_back(dequant_expect(i_s_axis_tdata));
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_real_q.size() == 0) begin
                    $error("real_bits: no request pending, actual %h", o_m_axis_tdata);
                    mismatch_count++;
                end else begin
                    if (o_m_axis_tdata !== expected_real_q[0]) begin
                        $error("real_bits: expected %h, actual %h",
                               expected_real_q[0], o_m_axis_tdata);
                        mismatch_count++;
                    end
                    void'(expected_real_q.pop_front());
                end
            end
        end
    end

    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // ---------------- drivers ----------------

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= {idx, 2'b00};
        i_pwdata  <= value;
        @(posedge i_clk);
        i_penable <= 1'b1;
        @(posedge i_clk);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        case (idx)
            REG_FMT:   cfg_fmt   = value[3:0];
            REG_QMODE: cfg_qmode = value[1:0];
            REG_FPOS:  cfg_fpos  = value[7:0];
            REG_ZOFF:  cfg_zoff  = value;
            REG_SCALE: cfg_scale = value;
            default: ;
        endcase
    endtask

    task automatic send_element(input logic [31:0] raw);
        if ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= raw;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_real_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [3:0] fmt, input logic [1:0] qmode,
                              input logic [7:0] fpos, input logic [31:0] zoff,
                              input logic [31:0] scale);
        wait_idle();
        write_reg(REG_FMT, {28'd0, fmt});
        write_reg(REG_QMODE, {30'd0, qmode});
        write_reg(REG_FPOS, {{24{fpos[7]}}, fpos});
        write_reg(REG_ZOFF, zoff);
        write_reg(REG_SCALE, scale);
    endtask

    // ---------------- tests ----------------

    task automatic test_reset_config();
        send_element(32'h3F80_0000);
        send_element(32'hFFFF_FFFF);
    endtask

    task automatic test_plain_formats();
        set_config(FMT_FP16, 2'd0, 8'd0, 32'd0, SCALE_RESET);
        send_element(32'h0000_8000);
        send_element(32'h0000_0001);
        send_element(32'h0000_03FF);
        send_element(32'hFFFF_FC01);
        send_element(32'h0000_7BFF);
        set_config(FMT_INT32, 2'd3, 8'd0, 32'd0, SCALE_RESET);
        send_element(32'h8000_0000);
        send_element(32'h0100_0003);
        set_config(4'd15, 2'd0, 8'd0, 32'd0, SCALE_RESET);
        send_element(32'h1234_56FF);
    endtask

    task automatic test_fixed_point();
        set_config(FMT_INT32, QM_DFP, 8'sd127, 32'd0, SCALE_RESET);
        send_element(32'h7FFF_FFFF);
        send_element(32'h0000_0003);
        set_config(FMT_FP16, QM_DFP, -8'sd128, 32'd0, SCALE_RESET);
        send_element(32'h0000_0080);
        send_element(32'h0000_0100);
        send_element(32'h0000_007F);
        set_config(FMT_INT16, QM_DFP, -8'sd127, 32'd0, SCALE_RESET);
        send_element(32'h0000_7FFF);
    endtask

    task automatic test_affine();
        set_config(FMT_UINT32, QM_AFFINE, 8'd0, 32'h8000_0000, 32'h0000_0001);
        send_element(32'hFFFF_FFFF);
        send_element(32'h0000_0000);
        set_config(FMT_FP32, QM_AFFINE, 8'd0, 32'h7FFF_FFFF, 32'hFF80_0000);
        send_element(32'h0000_00FF);
        set_config(FMT_INT8, QM_AFFINE, 8'd0, 32'hFFFF_FF80, 32'h7F80_0000);
        send_element(32'h0000_0080);
        set_config(FMT_CHAR, QM_AFFINE, 8'd0, 32'd5, 32'h7FC0_1234);
        send_element(32'h0000_0010);
    endtask

    function automatic logic [31:0] pick_raw();
        case ($urandom_range(3))
            0: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            1: return 32'($urandom_range(255));
            2: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_scale();
        case ($urandom_range(5))
            0: return SCALE_RESET;
            1: return {1'($urandom), 8'($urandom_range(0, 24)), 23'($urandom)};
            2: return {1'($urandom), 8'($urandom_range(230, 255)), 23'($urandom)};
            3: return {1'($urandom), 8'($urandom_range(100, 140)), 23'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] pick_fpos();
        case ($urandom_range(3))
            0: return 8'($urandom);
            1: return $urandom_range(1) ? 8'h80 : 8'h7F;
            default: return 8'($urandom_range(0, 40) - 20);
        endcase
    endfunction

    task automatic test_random_traffic();
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            set_config(4'($urandom_range(15)), 2'($urandom_range(3)), pick_fpos(),
                       $urandom_range(1) ? $urandom : 32'($urandom_range(300) - 150),
                       pick_scale());
            for (int n = 0; n < 50; n++) send_element(pick_raw());
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = 32'd0;
        i_m_axis_tready = 1'b0;
        i_psel          = 1'b0;
        i_penable       = 1'b0;
        i_pwrite        = 1'b0;
        i_paddr         = 5'd0;
        i_pwdata        = 32'd0;
        cfg_fmt         = FMT_FP32;
        cfg_qmode       = 2'd0;
        cfg_fpos        = 8'sd0;
        cfg_zoff        = 32'sd0;
        cfg_scale       = SCALE_RESET;
        mismatch_count  = 0;
        cycle_count     = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_config();
        test_plain_formats();
        test_fixed_point();
        test_affine();
        test_random_traffic();
        wait_idle();

        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
